@@ rtl/core/rsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rsp_pkg
// Types and constants for the relocation stream patcher.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int ADDR_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int SHIFT_W  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_DATA_W = 72;

  localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h80;
  localparam logic [1:0]        IDX_MASK   = 2'h3;
  localparam logic [SHIFT_W-1:0] GROUP_BITS = 6'd7;
  localparam logic [ADDR_W-1:0] LONG_BYTES = 32'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISP_CODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_DATA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_BSS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_JUMPTABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE     = 3'd5;

  // displacement selectors
  localparam logic [1:0] SEL_CODE      = 2'd0;
  localparam logic [1:0] SEL_DATA      = 2'd1;
  localparam logic [1:0] SEL_BSS       = 2'd2;
  localparam logic [1:0] SEL_JUMPTABLE = 2'd3;

  typedef enum logic [1:0] {
    KIND_PATCH     = 2'd0,
    KIND_PASS_END  = 2'd1,
    KIND_TABLE_END = 2'd2
  } result_kind_t;

  // record decoded in the first stage, finished in the second
  typedef struct packed {
    result_kind_t      kind;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        sel;
    logic              relative;
  } dec_rec_t;

endpackage

@@ rtl/core/relocation_stream_patcher_unit.sv @@
// ----------------------------------------------------------------------------
// relocation_stream_patcher_unit
// ULEB128 relocation table decoder giving patch addresses and deltas.
// ----------------------------------------------------------------------------
// Takes one table byte per clock with no bubbles while the output is not stalled. A result
// for the byte that completes a record or ends a pass is held in the first-stage register,
// then in the output register: the first stage gathers the 7-bit groups and advances the
// cursor (a 32-bit add that closes on itself, so records may follow each other every cycle),
// the second picks the displacement, forms the relative delta and runs the bounds check.
// Bytes that only continue a record, and every byte after the end of the relative pass, are
// taken but give no result until reset. The user must write configuration only while the
// block is idle; the block itself does not enforce this.
module relocation_stream_patcher_unit
  import rsp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [ADDR_W-1:0]       cfg_wdata,
  // table bytes
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [BYTE_W-1:0]       in_tdata,    // [7:0] reloc_byte
  // results
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,   // [31:0] patch_address, [63:32] patch_delta,
                                               // [64] out_of_range, [71:65] zero
  output logic [1:0]              out_tuser,   // [1:0] result_kind
  output logic                    out_tlast
);

  // configuration registers
  logic [ADDR_W-1:0] disp_code_r, disp_data_r, disp_bss_r, disp_jt_r;
  logic [ADDR_W-1:0] image_base_r;
  logic [ADDR_W-1:0] size_m4_r;
  logic              size_lt4_r;

  // decoder state
  logic [ADDR_W-1:0]  value_accum_r, value_accum_nxt;
  logic [SHIFT_W-1:0] shift_count_r, shift_count_nxt;
  logic [ADDR_W-1:0]  cursor_r, cursor_nxt;
  logic               relative_r, relative_nxt;
  logic               done_r, done_nxt;

  // pipeline
  logic      s1_valid_r;
  dec_rec_t  s1_r, s1_nxt;
  logic      s1_load;
  logic      out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  result_kind_t          out_kind_r;
  logic                  out_last_r, out_last_nxt;

  logic in_acc, out_free, s1_adv;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- first stage: byte decode and cursor ----------------
  logic [ADDR_W+BYTE_W-1:0] grp_wide;
  logic [ADDR_W-1:0]        full_val;
  logic [ADDR_W-1:0]        rec_addr;
  logic                     is_end, is_final;

  always_comb begin
    grp_wide = {{ADDR_W{1'b0}}, in_tdata & GROUP_MASK} << shift_count_r[4:0];
    full_val = value_accum_r;
    if (!shift_count_r[5]) begin
      full_val = value_accum_r | grp_wide[ADDR_W-1:0];
    end
    rec_addr = cursor_r + (full_val >> 2);
    is_end   = (shift_count_r == '0) && (in_tdata == '0);
    is_final = (in_tdata & CONT_MASK) == '0;
  end

  always_comb begin
    value_accum_nxt = value_accum_r;
    shift_count_nxt = shift_count_r;
    cursor_nxt      = cursor_r;
    relative_nxt    = relative_r;
    done_nxt        = done_r;
    s1_load         = 1'b0;
    s1_nxt          = s1_r;
    if (in_acc && !done_r) begin
      if (is_end) begin
        value_accum_nxt = '0;
        shift_count_nxt = '0;
        cursor_nxt      = image_base_r - 1'b1;
        s1_load         = 1'b1;
        s1_nxt.kind     = relative_r ? KIND_TABLE_END : KIND_PASS_END;
        s1_nxt.addr     = '0;
        s1_nxt.sel      = SEL_CODE;
        s1_nxt.relative = relative_r;
        if (relative_r) begin
          done_nxt = 1'b1;
        end else begin
          relative_nxt = 1'b1;
        end
      end else if (is_final) begin
        value_accum_nxt = '0;
        shift_count_nxt = '0;
        cursor_nxt      = rec_addr;
        s1_load         = 1'b1;
        s1_nxt.kind     = KIND_PATCH;
        s1_nxt.addr     = rec_addr;
        s1_nxt.sel      = full_val[1:0] & IDX_MASK;
        s1_nxt.relative = relative_r;
      end else begin
        value_accum_nxt = full_val;
        if (!shift_count_r[5]) begin
          shift_count_nxt = shift_count_r + GROUP_BITS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_code_r   <= '0;
      disp_data_r   <= '0;
      disp_bss_r    <= '0;
      disp_jt_r     <= '0;
      image_base_r  <= '0;
      size_m4_r     <= '0;
      size_lt4_r    <= 1'b1;
      value_accum_r <= '0;
      shift_count_r <= '0;
      cursor_r      <= '1;
      relative_r    <= 1'b0;
      done_r        <= 1'b0;
    end else begin
      value_accum_r <= value_accum_nxt;
      shift_count_r <= shift_count_nxt;
      cursor_r      <= cursor_nxt;
      relative_r    <= relative_nxt;
      done_r        <= done_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DISP_CODE:      disp_code_r <= cfg_wdata;
          REG_DISP_DATA:      disp_data_r <= cfg_wdata;
          REG_DISP_BSS:       disp_bss_r  <= cfg_wdata;
          REG_DISP_JUMPTABLE: disp_jt_r   <= cfg_wdata;
          REG_IMAGE_BASE: begin
            image_base_r <= cfg_wdata;
            cursor_r     <= cfg_wdata - 1'b1;
          end
          REG_IMAGE_SIZE: begin
            // keep size minus one longword for the bounds check
            size_m4_r  <= cfg_wdata - LONG_BYTES;
            size_lt4_r <= cfg_wdata < LONG_BYTES;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------- second stage: delta and bounds ----------------
  logic [ADDR_W-1:0] disp_sel, delta;
  logic [ADDR_W:0]   base_off;
  logic              in_range;

  always_comb begin
    case (s1_r.sel)
      SEL_CODE:      disp_sel = disp_code_r;
      SEL_DATA:      disp_sel = disp_data_r;
      SEL_BSS:       disp_sel = disp_bss_r;
      SEL_JUMPTABLE: disp_sel = disp_jt_r;
      default:       disp_sel = disp_code_r;
    endcase
    delta    = s1_r.relative ? (disp_sel - s1_r.addr) : disp_sel;
    base_off = {1'b0, s1_r.addr} - {1'b0, image_base_r};
    // borrow means the address lies below the base
    in_range = !base_off[ADDR_W] && !size_lt4_r && (base_off[ADDR_W-1:0] <= size_m4_r);
    out_data_nxt = '0;
    out_last_nxt = s1_r.kind == KIND_TABLE_END;
    if (s1_r.kind == KIND_PATCH) begin
      out_data_nxt[ADDR_W-1:0]        = s1_r.addr;
      out_data_nxt[2*ADDR_W-1:ADDR_W] = delta;
      out_data_nxt[2*ADDR_W]          = !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= s1_r.kind;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // ---------------- checks ----------------
  a_end_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_PATCH) |-> (out_tdata == '0))
    else $error("end result carries nonzero fields");

  a_last_on_table_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == KIND_TABLE_END)))
    else $error("tlast does not match table end");

  a_nothing_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result after end of table");

  a_in_range_above_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_PATCH && !out_tdata[2*ADDR_W])
      |-> (out_tdata[ADDR_W-1:0] >= image_base_r))
    else $error("in-range patch below image base");

endmodule
